// ----- sv/rpma_pkg.sv -----
`default_nettype none
package rpma_pkg;

  // sizing defaults
  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS      = 16;

  // fixed field widths
  localparam int COORD_W  = 32;
  localparam int RADIUS_W = 31;
  localparam int TOTAL_W  = 7;
  localparam int ANGLE_W  = 16;

  // operation codes
  localparam logic [1:0] OP_APPEND_BASE = 2'd0;
  localparam logic [1:0] OP_APPEND_NEW  = 2'd1;
  localparam logic [1:0] OP_SOLVE       = 2'd2;
  localparam logic [1:0] OP_CLEAR_BASE  = 2'd3;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(3 << FRAC_BITS);

  // CORDIC datapath
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CORDIC_W     = 34;
  localparam int ANGLE_Z_W    = 20;
  localparam int PI_Q13       = 25736;
  localparam int HALF_PI_Q13  = 12868;
  localparam int HALF_PI_Q16  = 102944;
  localparam int GAIN_Q30     = 652032874;

  // arctangent of 2^-k in units of 2^-16 rad
  function automatic logic signed [ANGLE_Z_W-1:0] atan_entry(input logic [STEP_W-1:0] k);
    logic signed [ANGLE_Z_W-1:0] v;
    case (k)
      4'd0:    v = ANGLE_Z_W'(51472);
      4'd1:    v = ANGLE_Z_W'(30386);
      4'd2:    v = ANGLE_Z_W'(16055);
      4'd3:    v = ANGLE_Z_W'(8150);
      4'd4:    v = ANGLE_Z_W'(4091);
      4'd5:    v = ANGLE_Z_W'(2047);
      4'd6:    v = ANGLE_Z_W'(1024);
      4'd7:    v = ANGLE_Z_W'(512);
      4'd8:    v = ANGLE_Z_W'(256);
      4'd9:    v = ANGLE_Z_W'(128);
      4'd10:   v = ANGLE_Z_W'(64);
      4'd11:   v = ANGLE_Z_W'(32);
      4'd12:   v = ANGLE_Z_W'(16);
      4'd13:   v = ANGLE_Z_W'(8);
      4'd14:   v = ANGLE_Z_W'(4);
      4'd15:   v = ANGLE_Z_W'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/rpma_ram.sv -----
`default_nettype none
module rpma_ram #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/rigid_2d_point_match_align_top.sv -----
`default_nettype none
// Rigid 2-D point-to-point alignment step.
// Command channel: an item is taken when start is high and busy is low.
//   operation 0/1 appends (coord_x, coord_y) to the base or new set, 3 empties
//   the base set; these produce no result, so loads can be streamed one beat
//   per cycle while no solve holds busy high. A full set ignores further appends.
// Operation 2 solves: it pairs each base point with its nearest new point
//   inside the match radius; with two or more pairs it divides the four sums
//   by the pair count, accumulates the covariance and finds the angle and
//   translation. It shows the result on done for exactly one cycle and
//   empties the new set. busy stays high throughout.
// The solve runs the match walk, the centroid divider, the covariance walk,
//   normalisation, CORDIC vectoring and rotation, then the translation;
//   with fewer than two pairs it ends right after the match walk.
//   Its pace is set by the single shared 34x34 multiplier and the one read
//   port of each point memory.
// Configuration: cfg_data is written into radius on a cfg_valid beat;
//   cfg_ready is always high. Write only while busy is low.
// Reset (rst, synchronous) empties both sets and reloads the radius of 3.0.
// The receiver cannot stall: a result must be taken in its done cycle.
module rigid_2d_point_match_align_top #(
  parameter int MAX_POINTS = rpma_pkg::MAX_POINTS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic [1:0]                             operation,
  input  wire logic signed [rpma_pkg::COORD_W-1:0]    coord_x,
  input  wire logic signed [rpma_pkg::COORD_W-1:0]    coord_y,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [rpma_pkg::RADIUS_W-1:0]          cfg_data,
  output logic                                        done,
  output logic                                        aligned,
  output logic [rpma_pkg::TOTAL_W-1:0]                pair_total,
  output logic signed [rpma_pkg::ANGLE_W-1:0]         rotation_angle,
  output logic signed [rpma_pkg::COORD_W-1:0]         shift_x,
  output logic signed [rpma_pkg::COORD_W-1:0]         shift_y
);

  localparam int IW     = $clog2(MAX_POINTS);
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = 33 + IW;
  localparam int DCW    = $clog2(SUM_W);
  localparam int ACC_W  = 68 + IW;
  localparam int VW     = rpma_pkg::CORDIC_W;
  localparam int ZW     = rpma_pkg::ANGLE_Z_W;
  localparam int SW     = rpma_pkg::STEP_W;
  localparam int PW     = 2 * VW;

  // sequencer states
  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_SOLVE  = 6'd1;
  localparam logic [5:0] S_R2     = 6'd2;
  localparam logic [5:0] S_MB     = 6'd3;
  localparam logic [5:0] S_MB2    = 6'd4;
  localparam logic [5:0] S_MN     = 6'd5;
  localparam logic [5:0] S_MD     = 6'd6;
  localparam logic [5:0] S_SQX    = 6'd7;
  localparam logic [5:0] S_SQY    = 6'd8;
  localparam logic [5:0] S_CMP    = 6'd9;
  localparam logic [5:0] S_MW     = 6'd10;
  localparam logic [5:0] S_DIVCHK = 6'd11;
  localparam logic [5:0] S_DIVLD  = 6'd12;
  localparam logic [5:0] S_DIVRUN = 6'd13;
  localparam logic [5:0] S_DIVST  = 6'd14;
  localparam logic [5:0] S_CB     = 6'd15;
  localparam logic [5:0] S_CP     = 6'd16;
  localparam logic [5:0] S_CN     = 6'd17;
  localparam logic [5:0] S_CD     = 6'd18;
  localparam logic [5:0] S_P1     = 6'd19;
  localparam logic [5:0] S_P2     = 6'd20;
  localparam logic [5:0] S_P3     = 6'd21;
  localparam logic [5:0] S_P4     = 6'd22;
  localparam logic [5:0] S_P5     = 6'd23;
  localparam logic [5:0] S_NLD    = 6'd24;
  localparam logic [5:0] S_NORM   = 6'd25;
  localparam logic [5:0] S_VEC    = 6'd26;
  localparam logic [5:0] S_ANG    = 6'd27;
  localparam logic [5:0] S_SCLD   = 6'd28;
  localparam logic [5:0] S_ROT    = 6'd29;
  localparam logic [5:0] S_ROTD   = 6'd30;
  localparam logic [5:0] S_T1     = 6'd31;
  localparam logic [5:0] S_T2     = 6'd32;
  localparam logic [5:0] S_T3     = 6'd33;
  localparam logic [5:0] S_T4     = 6'd34;
  localparam logic [5:0] S_T5     = 6'd35;
  localparam logic [5:0] S_T6     = 6'd36;
  localparam logic [5:0] S_T7     = 6'd37;
  localparam logic [5:0] S_OUT    = 6'd38;

  // shift toward zero, as the CORDIC steps need
  function automatic logic signed [VW-1:0] tshr(input logic signed [VW-1:0] v,
                                                 input logic [SW-1:0] s);
    logic [VW-1:0] m;
    m = v[VW-1] ? VW'(-v) : VW'(v);
    m = m >> s;
    return v[VW-1] ? -$signed(m) : $signed(m);
  endfunction

  // centre minus rounded (Q38.30) rotated centre, saturated
  function automatic logic signed [31:0] trans(input logic signed [31:0] c,
                                               input logic signed [PW-1:0] t);
    logic [PW-1:0] mag;
    logic [PW-1:0] rnd;
    logic signed [39:0] r;
    logic signed [39:0] d;
    mag = t[PW-1] ? PW'(-t) : PW'(t);
    rnd = (mag + (PW'(1) << 29)) >> 30;
    r = t[PW-1] ? -$signed(40'(rnd)) : $signed(40'(rnd));
    d = 40'(c) - r;
    if (d > 40'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (d < -40'sd2147483648) begin
      return 32'h8000_0000;
    end
    return d[31:0];
  endfunction

  logic [5:0]                 state;
  logic [CW-1:0]              base_count;
  logic [CW-1:0]              new_count;
  logic [rpma_pkg::RADIUS_W-1:0] radius;
  logic [IW-1:0]              bi;
  logic [IW-1:0]              nj;
  logic [IW-1:0]              bj;
  logic                       found;
  logic signed [31:0]         bx;
  logic signed [31:0]         by;
  logic signed [31:0]         nx;
  logic signed [31:0]         ny;
  logic signed [31:0]         bnx;
  logic signed [31:0]         bny;
  logic [32:0]                adx;
  logic [32:0]                ady;
  logic                       far;
  logic signed [PW-1:0]       prod;
  logic [61:0]                r2;
  logic [63:0]                d2;
  logic [63:0]                best;
  logic [CW-1:0]              pairs;
  logic signed [SUM_W-1:0]    sums [4];
  logic signed [31:0]         cen [4];
  logic [1:0]                 dk;
  logic [SUM_W-1:0]           dq;
  logic [CW-1:0]              rem;
  logic [DCW-1:0]             dcnt;
  logic                       dneg;
  logic signed [32:0]         bxd;
  logic signed [32:0]         byd;
  logic signed [32:0]         pxd;
  logic signed [32:0]         pyd;
  logic signed [ACC_W-1:0]    wx;
  logic signed [ACC_W-1:0]    wy;
  logic [ACC_W-1:0]           mx;
  logic [ACC_W-1:0]           my;
  logic                       xneg;
  logic                       yneg;
  logic signed [VW-1:0]       cx;
  logic signed [VW-1:0]       cy;
  logic signed [ZW-1:0]       cz;
  logic [SW-1:0]              step;
  logic                       flip;
  logic signed [VW-1:0]       cs;
  logic signed [VW-1:0]       sn;
  logic signed [PW-1:0]       tacc;
  logic signed [15:0]         ang;
  logic signed [31:0]         tx;
  logic signed [31:0]         ty;
  logic                       aligned_r;

  logic [63:0]                base_rd;
  logic [63:0]                new_rd;
  logic [IW:0]                pair_rd;

  logic                       take;
  logic                       base_we;
  logic                       new_we;

  // memories: points as {y, x}, pairs as {valid, index}
  assign take    = start && !busy;
  assign base_we = take && operation == rpma_pkg::OP_APPEND_BASE &&
                   base_count < CW'(MAX_POINTS);
  assign new_we  = take && operation == rpma_pkg::OP_APPEND_NEW &&
                   new_count < CW'(MAX_POINTS);

  rpma_ram #(.W(64), .D(MAX_POINTS)) u_base_ram (
    .clk(clk), .we(base_we), .waddr(base_count[IW-1:0]),
    .wdata({coord_y, coord_x}), .raddr(bi), .rdata(base_rd)
  );

  rpma_ram #(.W(64), .D(MAX_POINTS)) u_new_ram (
    .clk(clk), .we(new_we), .waddr(new_count[IW-1:0]),
    .wdata({coord_y, coord_x}), .raddr(nj), .rdata(new_rd)
  );

  rpma_ram #(.W(IW + 1), .D(MAX_POINTS)) u_pair_ram (
    .clk(clk), .we(state == S_MW), .waddr(bi),
    .wdata({found, bj}), .raddr(bi), .rdata(pair_rd)
  );

  // offsets of the current base/new pair
  logic signed [32:0] dx_c;
  logic signed [32:0] dy_c;
  logic signed [31:0] nrx;
  logic signed [31:0] nry;
  assign nrx  = $signed(new_rd[31:0]);
  assign nry  = $signed(new_rd[63:32]);
  assign dx_c = {bx[31], bx} - {nrx[31], nrx};
  assign dy_c = {by[31], by} - {nry[31], nry};

  logic [63:0] d2sum;
  logic        better;
  assign d2sum  = d2 + 64'(prod);
  assign better = !far && d2sum < {2'b00, r2} && (!found || d2sum < best);

  // shared multiplier operand select
  logic signed [VW-1:0] ma;
  logic signed [VW-1:0] mb;
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_SOLVE: begin
        ma = $signed(VW'(radius));
        mb = $signed(VW'(radius));
      end
      S_SQX: begin
        ma = $signed(VW'(adx));
        mb = $signed(VW'(adx));
      end
      S_SQY: begin
        ma = $signed(VW'(ady));
        mb = $signed(VW'(ady));
      end
      S_P1: begin
        ma = VW'(pxd);
        mb = VW'(byd);
      end
      S_P2: begin
        ma = VW'(pyd);
        mb = VW'(bxd);
      end
      S_P3: begin
        ma = VW'(pxd);
        mb = VW'(bxd);
      end
      S_P4: begin
        ma = VW'(pyd);
        mb = VW'(byd);
      end
      S_T1: begin
        ma = cs;
        mb = VW'(cen[2]);
      end
      S_T2: begin
        ma = sn;
        mb = VW'(cen[3]);
      end
      S_T4: begin
        ma = sn;
        mb = VW'(cen[2]);
      end
      S_T5: begin
        ma = cs;
        mb = VW'(cen[3]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // restoring divider step
  logic [CW:0]   trial;
  logic          dge;
  logic [CW-1:0] rem_next;
  assign trial    = {rem, dq[SUM_W-1]};
  assign dge      = trial >= {1'b0, pairs};
  assign rem_next = dge ? CW'(trial - {1'b0, pairs}) : CW'(trial);

  // CORDIC step terms
  logic signed [VW-1:0] tdx;
  logic signed [VW-1:0] tdy;
  logic signed [ZW-1:0] at;
  assign tdx = tshr(cy, step);
  assign tdy = tshr(cx, step);
  assign at  = rpma_pkg::atan_entry(step);

  // first-quadrant angle to Q3.13 with reflection
  logic signed [ZW-1:0] zc;
  logic signed [ZW-1:0] aq;
  always_comb begin
    if (cz < 0) begin
      zc = '0;
    end else if (cz > ZW'(rpma_pkg::HALF_PI_Q16)) begin
      zc = ZW'(rpma_pkg::HALF_PI_Q16);
    end else begin
      zc = cz;
    end
    aq = (zc + ZW'(4)) >>> 3;
    if (xneg) begin
      aq = ZW'(rpma_pkg::PI_Q13) - aq;
    end
    if (yneg) begin
      aq = -aq;
    end
  end

  // fold the angle into the right half plane for rotation
  logic signed [ZW-1:0] aw;
  logic                 aflip;
  always_comb begin
    aw    = ZW'(ang);
    aflip = 1'b0;
    if (aw > ZW'(rpma_pkg::HALF_PI_Q13)) begin
      aw    = aw - ZW'(rpma_pkg::PI_Q13);
      aflip = 1'b1;
    end else if (aw < -ZW'(rpma_pkg::HALF_PI_Q13)) begin
      aw    = aw + ZW'(rpma_pkg::PI_Q13);
      aflip = 1'b1;
    end
  end

  logic [ACC_W-1:0] orv;
  assign orv = mx | my;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      base_count <= '0;
      new_count  <= '0;
      radius     <= rpma_pkg::RADIUS_RESET;
    end else begin
      prod <= ma * mb;
      if (cfg_valid && cfg_ready) begin
        radius <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            case (operation)
              rpma_pkg::OP_APPEND_BASE: begin
                if (base_we) begin
                  base_count <= base_count + CW'(1);
                end
              end
              rpma_pkg::OP_APPEND_NEW: begin
                if (new_we) begin
                  new_count <= new_count + CW'(1);
                end
              end
              rpma_pkg::OP_CLEAR_BASE: begin
                base_count <= '0;
              end
              default: begin
                state <= S_SOLVE;
              end
            endcase
          end
        end
        S_SOLVE: begin
          pairs     <= '0;
          aligned_r <= 1'b0;
          ang       <= '0;
          tx        <= '0;
          ty        <= '0;
          for (int k = 0; k < 4; k++) begin
            sums[k] <= '0;
          end
          state <= S_R2;
        end
        S_R2: begin
          r2 <= prod[61:0];
          bi <= '0;
          state <= (base_count == '0) ? S_DIVCHK : S_MB;
        end
        // match walk
        S_MB: begin
          state <= S_MB2;
        end
        S_MB2: begin
          bx    <= $signed(base_rd[31:0]);
          by    <= $signed(base_rd[63:32]);
          nj    <= '0;
          found <= 1'b0;
          bj    <= '0;
          state <= (new_count == '0) ? S_MW : S_MN;
        end
        S_MN: begin
          state <= S_MD;
        end
        S_MD: begin
          nx    <= nrx;
          ny    <= nry;
          adx   <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
          ady   <= dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
          state <= S_SQX;
        end
        S_SQX: begin
          far   <= adx[32] | adx[31] | ady[32] | ady[31];
          state <= S_SQY;
        end
        S_SQY: begin
          d2    <= 64'(prod);
          state <= S_CMP;
        end
        S_CMP: begin
          if (better) begin
            found <= 1'b1;
            best  <= d2sum;
            bj    <= nj;
            bnx   <= nx;
            bny   <= ny;
          end
          if (CW'(nj) + CW'(1) < new_count) begin
            nj    <= nj + IW'(1);
            state <= S_MN;
          end else begin
            state <= S_MW;
          end
        end
        S_MW: begin
          if (found) begin
            pairs   <= pairs + CW'(1);
            sums[0] <= sums[0] + SUM_W'(bx);
            sums[1] <= sums[1] + SUM_W'(by);
            sums[2] <= sums[2] + SUM_W'(bnx);
            sums[3] <= sums[3] + SUM_W'(bny);
          end
          if (CW'(bi) + CW'(1) < base_count) begin
            bi    <= bi + IW'(1);
            state <= S_MB;
          end else begin
            state <= S_DIVCHK;
          end
        end
        // centroids
        S_DIVCHK: begin
          if (pairs < CW'(2)) begin
            state <= S_OUT;
          end else begin
            aligned_r <= 1'b1;
            dk        <= '0;
            state     <= S_DIVLD;
          end
        end
        S_DIVLD: begin
          dneg  <= sums[dk][SUM_W-1];
          dq    <= sums[dk][SUM_W-1] ? SUM_W'(-sums[dk]) : SUM_W'(sums[dk]);
          rem   <= '0;
          dcnt  <= '0;
          state <= S_DIVRUN;
        end
        S_DIVRUN: begin
          rem  <= rem_next;
          dq   <= {dq[SUM_W-2:0], dge};
          dcnt <= dcnt + DCW'(1);
          if (dcnt == DCW'(SUM_W - 1)) begin
            state <= S_DIVST;
          end
        end
        S_DIVST: begin
          cen[dk] <= dneg ? 32'(-$signed(dq)) : 32'(dq);
          if (dk == 2'd3) begin
            bi    <= '0;
            wx    <= '0;
            wy    <= '0;
            state <= S_CB;
          end else begin
            dk    <= dk + 2'd1;
            state <= S_DIVLD;
          end
        end
        // covariance walk
        S_CB: begin
          state <= S_CP;
        end
        S_CP: begin
          if (pair_rd[IW]) begin
            bxd   <= {base_rd[31], base_rd[31:0]} - 33'(cen[0]);
            byd   <= {base_rd[63], base_rd[63:32]} - 33'(cen[1]);
            nj    <= pair_rd[IW-1:0];
            state <= S_CN;
          end else if (CW'(bi) + CW'(1) < base_count) begin
            bi    <= bi + IW'(1);
            state <= S_CB;
          end else begin
            state <= S_NLD;
          end
        end
        S_CN: begin
          state <= S_CD;
        end
        S_CD: begin
          pxd   <= {nrx[31], nrx} - 33'(cen[2]);
          pyd   <= {nry[31], nry} - 33'(cen[3]);
          state <= S_P1;
        end
        S_P1: begin
          state <= S_P2;
        end
        S_P2: begin
          wy    <= wy + ACC_W'(prod);
          state <= S_P3;
        end
        S_P3: begin
          wy    <= wy - ACC_W'(prod);
          state <= S_P4;
        end
        S_P4: begin
          wx    <= wx + ACC_W'(prod);
          state <= S_P5;
        end
        S_P5: begin
          wx <= wx + ACC_W'(prod);
          if (CW'(bi) + CW'(1) < base_count) begin
            bi    <= bi + IW'(1);
            state <= S_CB;
          end else begin
            state <= S_NLD;
          end
        end
        // normalise both terms so the larger has 30 bits
        S_NLD: begin
          xneg <= wx[ACC_W-1];
          yneg <= wy[ACC_W-1];
          mx   <= wx[ACC_W-1] ? ACC_W'(-wx) : ACC_W'(wx);
          my   <= wy[ACC_W-1] ? ACC_W'(-wy) : ACC_W'(wy);
          if (wx == '0 && wy == '0) begin
            ang   <= '0;
            state <= S_SCLD;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (|orv[ACC_W-1:30]) begin
            mx <= mx >> 1;
            my <= my >> 1;
          end else if (!orv[29]) begin
            mx <= mx << 1;
            my <= my << 1;
          end else begin
            cx    <= $signed(VW'(mx[29:0]));
            cy    <= $signed(VW'(my[29:0]));
            cz    <= '0;
            step  <= '0;
            state <= S_VEC;
          end
        end
        S_VEC: begin
          if (cy > 0) begin
            cx <= cx + tdx;
            cy <= cy - tdy;
            cz <= cz + at;
          end else begin
            cx <= cx - tdx;
            cy <= cy + tdy;
            cz <= cz - at;
          end
          step <= step + SW'(1);
          if (step == SW'(rpma_pkg::CORDIC_STEPS - 1)) begin
            state <= S_ANG;
          end
        end
        S_ANG: begin
          ang   <= 16'(aq);
          state <= S_SCLD;
        end
        // cos and sin of the angle
        S_SCLD: begin
          cx    <= VW'(rpma_pkg::GAIN_Q30);
          cy    <= '0;
          cz    <= aw <<< 3;
          flip  <= aflip;
          step  <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (cz >= 0) begin
            cx <= cx - tdx;
            cy <= cy + tdy;
            cz <= cz - at;
          end else begin
            cx <= cx + tdx;
            cy <= cy - tdy;
            cz <= cz + at;
          end
          step <= step + SW'(1);
          if (step == SW'(rpma_pkg::CORDIC_STEPS - 1)) begin
            state <= S_ROTD;
          end
        end
        S_ROTD: begin
          cs    <= flip ? -cx : cx;
          sn    <= flip ? -cy : cy;
          state <= S_T1;
        end
        // translation
        S_T1: begin
          state <= S_T2;
        end
        S_T2: begin
          tacc  <= prod;
          state <= S_T3;
        end
        S_T3: begin
          tacc  <= tacc - prod;
          state <= S_T4;
        end
        S_T4: begin
          tx    <= trans(cen[0], tacc);
          state <= S_T5;
        end
        S_T5: begin
          tacc  <= prod;
          state <= S_T6;
        end
        S_T6: begin
          tacc  <= tacc + prod;
          state <= S_T7;
        end
        S_T7: begin
          ty    <= trans(cen[1], tacc);
          state <= S_OUT;
        end
        S_OUT: begin
          new_count <= '0;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ports
  assign busy           = state != S_IDLE;
  assign cfg_ready      = 1'b1;
  assign done           = state == S_OUT;
  assign aligned        = aligned_r;
  assign pair_total     = rpma_pkg::TOTAL_W'(pairs);
  assign rotation_angle = ang;
  assign shift_x        = tx;
  assign shift_y        = ty;

endmodule
`default_nettype wire

// ----- sv/rpma_chk.sv -----
`default_nettype none
module rpma_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  operation,
  input wire logic        done,
  input wire logic        aligned,
  input wire logic [6:0]  pair_total,
  input wire logic signed [15:0] rotation_angle,
  input wire logic signed [31:0] shift_x,
  input wire logic signed [31:0] shift_y
);

  // loads and clears never give a result beat
  a_no_result_on_load: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation != rpma_pkg::OP_SOLVE) |=> !done)
    else $error("result beat after a load or clear");

  // an unaligned result carries a zero transform
  a_unaligned_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !aligned) |-> (rotation_angle == 16'sd0 && shift_x == 32'sd0 &&
                           shift_y == 32'sd0))
    else $error("unaligned result with non-zero transform");

  // aligned exactly when two or more pairs
  a_aligned_pairs: assert property (@(posedge clk) disable iff (rst)
    done |-> (aligned == (pair_total >= 7'd2)))
    else $error("aligned flag disagrees with pair count");

  // a result comes out while the solve still holds the channel
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result beat while idle");

  // one beat per solve
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beat repeated");

endmodule

bind rigid_2d_point_match_align_top rpma_chk u_rpma_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
  .done(done), .aligned(aligned), .pair_total(pair_total),
  .rotation_angle(rotation_angle), .shift_x(shift_x), .shift_y(shift_y)
);
`default_nettype wire
